FILE: rtl/core/fct_pkg.sv
// Shared types and constants for the frustum cull test block.
package fct_pkg;

    // Number of plane registers on the configuration port.
    localparam int NUM_REGS = 6;
    // Number of planes that take part in the test (1 to NUM_REGS).
    localparam int NUM_PLANES = 6;
    // Width of the register index on the configuration port.
    localparam int CFG_IDX_W = $clog2(NUM_REGS);
    // Stream word widths.
    localparam int IN_TDATA_W = 160;
    localparam int OUT_TDATA_W = 8;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEFT   = CFG_IDX_W'(0),
        REG_RIGHT  = CFG_IDX_W'(1),
        REG_BOTTOM = CFG_IDX_W'(2),
        REG_TOP    = CFG_IDX_W'(3),
        REG_NEAR   = CFG_IDX_W'(4),
        REG_FAR    = CFG_IDX_W'(5)
    } t_reg_idx;

    // Volume kind carried in tuser.
    typedef enum logic [0:0] {
        CMD_BOX    = 1'b0,
        CMD_SPHERE = 1'b1
    } t_cmd;

    // One plane: normal a, b, c in signed Q1.14, offset d in coordinate units.
    typedef struct packed {
        logic signed [15:0] d;
        logic signed [15:0] c;
        logic signed [15:0] b;
        logic signed [15:0] a;
    } t_plane;

    // A point or corner in signed 16-bit coordinates.
    typedef struct packed {
        logic signed [15:0] z;
        logic signed [15:0] y;
        logic signed [15:0] x;
    } t_vec;

    // One bounding volume as it travels through the pipeline.
    typedef struct packed {
        t_cmd        command;
        t_vec        vmin;
        t_vec        vmax;
        t_vec        center;
        logic [14:0] radius;
    } t_item;

endpackage

FILE: rtl/core/fct_plane_regs.sv
// Plane register file written through the configuration port.
module fct_plane_regs
    import fct_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [63:0]          i_cfg_data,
    output t_plane [NUM_REGS-1:0] o_planes
);

    t_plane [NUM_REGS-1:0] r_planes;

    // Writes to an index past the last plane register are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_planes <= '0;
        end else if (i_cfg_we && (i_cfg_idx <= REG_FAR)) begin
            r_planes[i_cfg_idx] <= t_plane'(i_cfg_data);
        end
    end

    assign o_planes = r_planes;

endmodule

FILE: rtl/core/fct_plane_lane.sv
// One plane test lane: corner select and products, then the signed sum.
module fct_plane_lane
    import fct_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_en,
    input  t_plane i_plane,
    input  t_item  i_item,
    output logic   o_reject
);

    logic signed [15:0] w_px;
    logic signed [15:0] w_py;
    logic signed [15:0] w_pz;
    logic signed [16:0] w_rad;
    logic signed [16:0] w_ofs;
    logic signed [31:0] n_prod_x;
    logic signed [31:0] n_prod_y;
    logic signed [31:0] n_prod_z;
    logic signed [31:0] r_prod_x;
    logic signed [31:0] r_prod_y;
    logic signed [31:0] r_prod_z;
    logic signed [30:0] r_ofs;
    logic signed [33:0] w_sum;

    // A sphere uses its center; a box uses the corner farthest along the normal.
    always_comb begin
        if (i_item.command == CMD_SPHERE) begin
            w_px = i_item.center.x;
            w_py = i_item.center.y;
            w_pz = i_item.center.z;
        end else begin
            w_px = (i_plane.a > 16'sd0) ? i_item.vmax.x : i_item.vmin.x;
            w_py = (i_plane.b > 16'sd0) ? i_item.vmax.y : i_item.vmin.y;
            w_pz = (i_plane.c > 16'sd0) ? i_item.vmax.z : i_item.vmin.z;
        end
    end

    // The sphere radius folds into the offset, so both modes reject on a negative sum.
    assign w_rad = (i_item.command == CMD_SPHERE) ? {2'b00, i_item.radius} : '0;
    assign w_ofs = {i_plane.d[15], i_plane.d} + w_rad;

    assign n_prod_x = i_plane.a * w_px;
    assign n_prod_y = i_plane.b * w_py;
    assign n_prod_z = i_plane.c * w_pz;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod_x <= n_prod_x;
            r_prod_y <= n_prod_y;
            r_prod_z <= n_prod_z;
            r_ofs    <= {w_ofs, 14'b0};
        end
    end

    // Exact distance, scaled by 2^14; its sign bit is the reject flag.
    assign w_sum = {{2{r_prod_x[31]}}, r_prod_x} + {{2{r_prod_y[31]}}, r_prod_y}
                 + {{2{r_prod_z[31]}}, r_prod_z} + {{3{r_ofs[30]}}, r_ofs};
    assign o_reject = w_sum[33];

endmodule

FILE: rtl/core/frustum_cull_test_top.sv
// Top level of the frustum cull test block.
//
// Tests one bounding volume per word against the configured frustum planes.
// Input words arrive on the s_axis channel: tuser selects a box (0) or a
// sphere (1), tdata carries the box bounds, the sphere center and the radius.
// Each input word yields exactly one output word on the m_axis channel, whose
// tdata bit 0 is the visible flag.
// Plane registers are written through the cfg port (index 0 left through
// 5 far); they may be written only while no word is in flight.
// Pipeline: three registers (input register, product register per plane,
// result register); a word's result shows on m_axis once it has passed them.
// Throughput: one word per cycle while the receiver takes every result word.
// When the receiver stalls, the result holds and the pipeline keeps taking
// words until its empty stages fill, then tready drops.
// Reset clears all plane registers (every volume is then visible) and empties
// the pipeline.
module frustum_cull_test_top
    import fct_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration write port.
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [63:0]            i_cfg_data,
    // Input stream.
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // min_x, min_y, min_z, max_x, max_y, max_z, center_x, center_y, center_z,
    // radius (15 bits), one zero pad bit at the top
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // command
    input  logic                   i_s_axis_tuser,
    // Output stream.
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // visible, seven zero pad bits
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    t_plane [NUM_REGS-1:0]   w_planes;
    t_item                   n_item;
    t_item                   r_item;
    logic                    r_v0;
    logic                    r_v1;
    logic                    r_v2;
    logic                    r_vis;
    logic                    w_rdy0;
    logic                    w_rdy1;
    logic                    w_rdy2;
    logic [NUM_PLANES-1:0]   w_reject;

    fct_plane_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_planes   (w_planes)
    );

    // A stage may load when it is empty or its word moves on.
    assign w_rdy2 = !r_v2 || i_m_axis_tready;
    assign w_rdy1 = !r_v1 || w_rdy2;
    assign w_rdy0 = !r_v0 || w_rdy1;
    assign o_s_axis_tready = w_rdy0;

    // Unpack the input word.
    always_comb begin
        n_item.command  = t_cmd'(i_s_axis_tuser);
        n_item.vmin.x   = i_s_axis_tdata[15:0];
        n_item.vmin.y   = i_s_axis_tdata[31:16];
        n_item.vmin.z   = i_s_axis_tdata[47:32];
        n_item.vmax.x   = i_s_axis_tdata[63:48];
        n_item.vmax.y   = i_s_axis_tdata[79:64];
        n_item.vmax.z   = i_s_axis_tdata[95:80];
        n_item.center.x = i_s_axis_tdata[111:96];
        n_item.center.y = i_s_axis_tdata[127:112];
        n_item.center.z = i_s_axis_tdata[143:128];
        n_item.radius   = i_s_axis_tdata[158:144];
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (w_rdy0) begin
            r_item <= n_item;
        end
    end

    // One lane per tested plane.
    for (genvar g = 0; g < NUM_PLANES; g++) begin : g_lane
        fct_plane_lane u_lane (
            .i_clk    (i_clk),
            .i_en     (w_rdy1),
            .i_plane  (w_planes[g]),
            .i_item   (r_item),
            .o_reject (w_reject[g])
        );
    end

    // Result register: visible unless some plane rejects.
    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r_vis <= ~(|w_reject);
        end
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_rdy0) begin
                r_v0 <= i_s_axis_tvalid;
            end
            if (w_rdy1) begin
                r_v1 <= r_v0;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
        end
    end

    assign o_m_axis_tvalid = r_v2;
    assign o_m_axis_tdata  = {(OUT_TDATA_W-1)'(0), r_vis};

endmodule

FILE: rtl/core/fct_checker.sv
// Port-level checks for the frustum cull test block, bound to its top level.
module fct_checker
    import fct_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_axis_tvalid,
    input logic                   o_s_axis_tready,
    input logic                   o_m_axis_tvalid,
    input logic                   i_m_axis_tready,
    input logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output word valid right after reset");

    // A stalled result word holds.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled output word changed");

    // Only the visible flag is carried; the pad bits stay zero.
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[OUT_TDATA_W-1:1] == '0))
        else $error("output pad bits not zero");

    // With no result waiting, the block must take a new word.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled while output side is empty");

    // A word accepted while the output side is empty and the receiver is ready
    // puts a valid word in the result register, even if the receiver then stalls.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && !o_m_axis_tvalid && i_m_axis_tready
            |=> ##2 o_m_axis_tvalid)
        else $error("result word late");

endmodule

bind frustum_cull_test_top fct_checker u_fct_checker (.*);

FILE: tb/tb_frustum_cull_test_top.sv
// Self-checking testbench for the frustum cull test block: streamed volumes against a plane predictor.
`timescale 1ns / 1ps

module tb_frustum_cull_test_top
    import fct_pkg::*;
();

    // One unit of a Q1.14 normal component, used to scale the plane offset.
    localparam longint Q14_ONE = 64'sd16384;
    // Number of random words per random phase, and the phase count.
    localparam int RAND_WORDS = 275;
    localparam int RAND_PHASES = 6;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = '0;
    logic [63:0]            i_cfg_data = '0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    // min_x, min_y, min_z, max_x, max_y, max_z, center_x, center_y, center_z,
    // radius (15 bits), one zero pad bit at the top
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    // command
    logic                   i_s_axis_tuser = 1'b0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    // visible, seven zero pad bits
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;

    // Plane registers as the block should hold them.
    t_plane plane_cfg [NUM_REGS];
    // Volumes waiting to be sent, and visible flags waiting to come back.
    t_item  pending_items [$];
    logic   visible_expected [$];
    t_item  bus_item;
    t_item  staged;
    logic   want_visible;
    // Set during one phase to turn off all random idling on both sides.
    bit     calm = 1'b0;
    int     error_count = 0;

    frustum_cull_test_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Visibility of one volume against the current planes.
    function automatic logic visible_of(t_item it);
        t_plane p;
        longint x, y, z, scaled_dist, limit;
        logic   vis;
        vis = 1'b1;
        for (int i = 0; i < NUM_PLANES; i++) begin
            p = plane_cfg[i];
            if (it.command == CMD_SPHERE) begin
                x = $signed(it.center.x);
                y = $signed(it.center.y);
                z = $signed(it.center.z);
                limit = -(longint'(it.radius) * Q14_ONE);
            end else begin
                // Positive vertex: max bound only where the normal is strictly positive.
                x = ($signed(p.a) > 0) ? $signed(it.vmax.x) : $signed(it.vmin.x);
                y = ($signed(p.b) > 0) ? $signed(it.vmax.y) : $signed(it.vmin.y);
                z = ($signed(p.c) > 0) ? $signed(it.vmax.z) : $signed(it.vmin.z);
                limit = 0;
            end
            scaled_dist = longint'($signed(p.a)) * x + longint'($signed(p.b)) * y +
                          longint'($signed(p.c)) * z + longint'($signed(p.d)) * Q14_ONE;
            if (scaled_dist < limit) begin
                vis = 1'b0;
            end
        end
        return vis;
    endfunction

    function automatic logic [63:0] plane_of(int a, int b, int c, int d);
        return {16'(d), 16'(c), 16'(b), 16'(a)};
    endfunction

    function automatic t_vec vec3(int x, int y, int z);
        t_vec v;
        v.x = 16'(x);
        v.y = 16'(y);
        v.z = 16'(z);
        return v;
    endfunction

    // Plausible frustum plane: normal components within +/-1.0, origin mostly inside.
    function automatic logic [63:0] frustum_plane(int reach);
        return plane_of(int'($urandom_range(0, 32768)) - 16384,
                        int'($urandom_range(0, 32768)) - 16384,
                        int'($urandom_range(0, 32768)) - 16384,
                        int'($urandom_range(0, reach)) - reach / 4);
    endfunction

    // Plane whose fields are all drawn from the corner values of 16 bits.
    function automatic logic [63:0] extreme_plane();
        logic [15:0] corners [5];
        logic [63:0] p;
        corners = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001};
        for (int k = 0; k < 4; k++) begin
            p[16*k +: 16] = corners[$urandom_range(0, 4)];
        end
        return p;
    endfunction

    function automatic logic [15:0] rand_coord(int span);
        if ($urandom_range(0, 7) == 0) begin
            return 16'($urandom);
        end
        return 16'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    // Random volume; boxes are mostly well ordered, about one axis in ten inverted.
    function automatic t_item rand_item(int span);
        t_item       it;
        logic [15:0] u, v, t;
        it.command = t_cmd'($urandom_range(0, 1));
        for (int k = 0; k < 3; k++) begin
            u = rand_coord(span);
            v = rand_coord(span);
            if (($signed(u) > $signed(v)) != ($urandom_range(0, 9) == 0)) begin
                t = u;
                u = v;
                v = t;
            end
            it.vmin[16*k +: 16] = u;
            it.vmax[16*k +: 16] = v;
            it.center[16*k +: 16] = rand_coord(span);
        end
        if ($urandom_range(0, 7) == 0) begin
            it.radius = 15'($urandom);
        end else begin
            it.radius = 15'($urandom_range(0, span / 2));
        end
        return it;
    endfunction

    // Box with random contents in the sphere fields, which the block must ignore.
    function automatic t_item box_item(t_vec lo, t_vec hi);
        t_item it;
        it = rand_item(32767);
        it.command = CMD_BOX;
        it.vmin = lo;
        it.vmax = hi;
        return it;
    endfunction

    // Sphere with random contents in the box fields.
    function automatic t_item sphere_item(t_vec ctr, int rad);
        t_item it;
        it = rand_item(32767);
        it.command = CMD_SPHERE;
        it.center = ctr;
        it.radius = 15'(rad);
        return it;
    endfunction

    // Append one volume to the send queue.
    task automatic queue_item(input t_item it);
        pending_items.insert(pending_items.size(), it);
    endtask

    // Register write; the predictor copy follows at once since the block is idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        if (idx < NUM_REGS) begin
            plane_cfg[idx] = value;
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Wait until every queued word has been sent and every result has come back.
    task automatic wait_drained();
        while (pending_items.size() != 0 || i_s_axis_tvalid || visible_expected.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    // Input driver: offers the next pending word, idling at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                visible_expected.insert(visible_expected.size(), visible_of(bus_item));
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (pending_items.size() != 0 && (calm || $urandom_range(0, 99) >= 34)) begin
                    staged = pending_items.pop_front();
                    bus_item <= staged;
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tuser <= staged.command;
                    i_s_axis_tdata <= {1'b0, staged.radius,
                                       staged.center.z, staged.center.y, staged.center.x,
                                       staged.vmax.z, staged.vmax.y, staged.vmax.x,
                                       staged.vmin.z, staged.vmin.y, staged.vmin.x};
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: checks each result word against the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (visible_expected.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, actual visible=%0b",
                             $time, o_m_axis_tdata[0]);
                    error_count++;
                end else begin
                    want_visible = visible_expected.pop_front();
                    if (o_m_axis_tdata[0] !== want_visible) begin
                        $display("%0t: visible mismatch, expected %0b, actual %0b",
                                 $time, want_visible, o_m_axis_tdata[0]);
                        error_count++;
                    end
                end
            end
            i_m_axis_tready <= calm || ($urandom_range(0, 99) >= 34);
        end
    end

    // Stimulus and end of run.
    initial begin
        logic [63:0] value;
        int          span;
        int          reach;
        int          lone;
        for (int i = 0; i < NUM_REGS; i++) begin
            plane_cfg[i] = '0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset planes: everything is visible, even at the coordinate extremes.
        queue_item(box_item(vec3(-32768, -32768, -32768), vec3(32767, 32767, 32767)));
        queue_item(box_item(vec3(32767, 32767, 32767), vec3(-32768, -32768, -32768)));
        queue_item(sphere_item(vec3(-32768, -32768, -32768), 0));
        queue_item(sphere_item(vec3(32767, 32767, 32767), 32767));
        wait_drained();

        // Single plane x >= 0: distances of exactly zero or exactly -radius pass.
        write_reg(REG_LEFT, plane_of(16384, 0, 0, 0));
        @(negedge i_clk);
        queue_item(box_item(vec3(-10, 0, 0), vec3(0, 0, 0)));
        queue_item(box_item(vec3(-10, 0, 0), vec3(-1, 0, 0)));
        queue_item(box_item(vec3(100, 0, 0), vec3(-100, 0, 0)));
        queue_item(sphere_item(vec3(-5, 0, 0), 5));
        queue_item(sphere_item(vec3(-5, 0, 0), 4));
        queue_item(sphere_item(vec3(0, 0, 0), 0));
        wait_drained();

        // Single plane x <= 0: a negative normal takes the min bound, inverted or not.
        write_reg(REG_LEFT, plane_of(-16384, 0, 0, 0));
        @(negedge i_clk);
        queue_item(box_item(vec3(100, 0, 0), vec3(-100, 0, 0)));
        queue_item(box_item(vec3(0, 0, 0), vec3(50, 0, 0)));
        wait_drained();

        // Extreme plane fields; writes above the last register must change nothing.
        write_reg(REG_LEFT, plane_of(-32768, 32767, 0, -32768));
        write_reg(REG_FAR, plane_of(0, 0, -32768, 32767));
        for (int k = NUM_REGS; k < (1 << CFG_IDX_W); k++) begin
            write_reg(CFG_IDX_W'(k), {$urandom, $urandom});
        end
        @(negedge i_clk);
        queue_item(box_item(vec3(-32768, -32768, -32768), vec3(32767, 32767, 32767)));
        queue_item(box_item(vec3(32767, 32767, 32767), vec3(-32768, -32768, -32768)));
        queue_item(sphere_item(vec3(-32768, 32767, -32768), 32767));
        queue_item(sphere_item(vec3(32767, -32768, 32767), 0));
        queue_item(sphere_item(vec3(0, 0, 0), 32767));
        queue_item(box_item(vec3(0, 0, 0), vec3(0, 0, 0)));
        wait_drained();

        // Random phases, each with its own plane set; phases 1, 3 and 4 share the full coordinate spread.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            calm = (ph == 2);
            lone = $urandom_range(0, NUM_REGS - 1);
            case (ph)
                0: begin reach = 3000; span = 4000; end
                2: begin reach = 20000; span = 20000; end
                5: begin reach = 40; span = 60; end
                default: begin reach = 0; span = 32767; end
            endcase
            for (int r = 0; r < NUM_REGS; r++) begin
                case (ph)
                    1: value = {$urandom, $urandom};
                    3: value = extreme_plane();
                    4: value = (r == lone) ? {$urandom, $urandom} : 64'd0;
                    default: value = frustum_plane(reach);
                endcase
                write_reg(CFG_IDX_W'(r), value);
            end
            @(negedge i_clk);
            for (int n = 0; n < RAND_WORDS; n++) begin
                queue_item(rand_item(span));
            end
            wait_drained();
        end

        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/fct_pkg.sv
rtl/core/fct_plane_regs.sv
rtl/core/fct_plane_lane.sv
rtl/core/frustum_cull_test_top.sv
rtl/core/fct_checker.sv
tb/tb_frustum_cull_test_top.sv
